>>> hdl/slrs_pkg.sv
// ----------------------------------------------------------------------------
// slrs_pkg - shared constants for the shuffled random source
// Generator constants of the minimal-standard multiplicative generator.
// ----------------------------------------------------------------------------
package slrs_pkg;

  // Multiplier and prime modulus of the generator (x = A*x mod M).
  localparam logic [14:0] MUL_A = 15'd16807;
  localparam logic [31:0] MOD_M = 32'h7FFF_FFFF;

  // Extra generator steps run ahead of the table fill when reseeding.
  localparam int WARMUP = 8;

  // Widths of the packed stream payloads.
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 64;

endpackage

>>> hdl/shuffled_lcg_random_source.sv
// ----------------------------------------------------------------------------
// shuffled_lcg_random_source - shuffled minimal-standard random source
// Multiplicative generator (x = 16807*x mod 2^31-1) feeding a shuffle table.
// ----------------------------------------------------------------------------
//
//  Channel | Ports            | Payload (lowest bit first)
//  --------+------------------+------------------------------------------------
//  input   | in_tvalid/tready | in_tuser: req_type; in_tdata: seed_value
//  result  | out_tvalid/ready | out_tdata: sample, generator_value, zero pad
//
// A plain draw runs through the transfer, a state for the 32x15 bit multiply
// and the table read, and a state for the modular fold and the table write.
// When the slot divisor is not a power of two, an extra state compares the
// previous sample against the constant slot boundaries. A reseed first runs
// the generator through its warm-up steps, each a multiply state followed by
// a fold state. Reset clears the generator value and the previous sample, so
// the first draw always reseeds. A result that is not yet taken holds the
// next draw in its final state; the input side waits meanwhile.
//
module shuffled_lcg_random_source #(
  parameter int TABLE_SIZE = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] seed_value (signed)
  input  logic        in_tuser,   // [0] req_type
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // [30:0] sample, [61:31] generator_value
);

  // Table address width, step counter width and the slot divisor.
  localparam int AW        = $clog2(TABLE_SIZE);
  localparam int CW        = $clog2(TABLE_SIZE + slrs_pkg::WARMUP);
  localparam longint SLOT_DIV = 1 + (64'd2147483646 / TABLE_SIZE);
  localparam bit SLOT_POW2 = ((SLOT_DIV & (SLOT_DIV - 1)) == 0);
  localparam int SLOT_SH   = $clog2(SLOT_DIV);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SMUL = 3'd1;  // reseed: multiply
  localparam logic [2:0] S_SRED = 3'd2;  // reseed: fold and table fill
  localparam logic [2:0] S_DIV  = 3'd3;  // draw: slot division
  localparam logic [2:0] S_DMUL = 3'd4;  // draw: multiply, table read
  localparam logic [2:0] S_DRED = 3'd5;  // draw: fold, emit, table write
  localparam logic [2:0] DRAW_ENTRY = SLOT_POW2 ? S_DMUL : S_DIV;

  logic [2:0]    state_r, state_nxt;
  logic [31:0]   lcg_r, lcg_nxt;       // generator value (two's complement)
  logic [30:0]   last_r, last_nxt;     // previous sample
  logic [46:0]   prod_r, prod_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] q_r, q_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [30:0]   out_sample_r, out_sample_nxt;
  logic [30:0]   out_gen_r, out_gen_nxt;

  logic [31:0]   lcg_eff;
  logic          need_seed;
  logic [31:0]   seed_start;
  logic [31:0]   fold_sum;
  logic [30:0]   fold_val;
  logic [30:0]   slot_wide;
  logic [AW-1:0] slot;
  logic [AW-1:0] slot_quo;

  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  logic [30:0]   ram_wr_data;
  logic          ram_rd_en;
  logic [30:0]   ram_rd_data;

  // Generator value in effect for this draw, after an optional seed load.
  assign lcg_eff    = in_tuser ? in_tdata : lcg_r;
  assign need_seed  = ($signed(lcg_eff) <= 32'sd0) || (last_r == 31'd0);
  // A negative value is negated; the most negative one becomes 2^31.
  assign seed_start = ($signed(lcg_eff) < 32'sd0) ? (~lcg_eff + 32'd1) : 32'd1;

  // Mersenne fold: 2^31 is 1 modulo M, so high bits are added to the low
  // ones, and one conditional subtract brings the sum below M.
  assign fold_sum = 32'(prod_r[30:0]) + 32'(prod_r[46:31]);
  assign fold_val = (fold_sum >= slrs_pkg::MOD_M) ?
                    31'(fold_sum - slrs_pkg::MOD_M) : fold_sum[30:0];

  // Slot boundaries k*SLOT_DIV are constants that rise with k, so the last
  // boundary the previous sample reaches is the quotient.
  always_comb begin
    slot_quo = '0;
    for (int k = 1; k < TABLE_SIZE; k++) begin
      if ({1'b0, last_r} >= 32'(longint'(k) * SLOT_DIV)) begin
        slot_quo = AW'(k);
      end
    end
  end

  // Slot selected by the previous sample, clamped to the table.
  assign slot_wide = SLOT_POW2 ? (last_r >> SLOT_SH) : 31'(q_r);
  assign slot = (slot_wide >= 31'(TABLE_SIZE)) ? AW'(TABLE_SIZE - 1) :
                                                 slot_wide[AW-1:0];

  always_comb begin
    state_nxt      = state_r;
    lcg_nxt        = lcg_r;
    last_nxt       = last_r;
    prod_nxt       = prod_r;
    cnt_nxt        = cnt_r;
    q_nxt          = q_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_sample_nxt = out_sample_r;
    out_gen_nxt    = out_gen_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = slot;
    ram_wr_data    = fold_val;
    ram_rd_en      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (need_seed) begin
            lcg_nxt   = seed_start;
            cnt_nxt   = CW'(TABLE_SIZE + slrs_pkg::WARMUP - 1);
            state_nxt = S_SMUL;
          end else begin
            lcg_nxt   = lcg_eff;
            state_nxt = DRAW_ENTRY;
          end
        end
      end
      S_SMUL: begin
        prod_nxt  = lcg_r * slrs_pkg::MUL_A;
        state_nxt = S_SRED;
      end
      S_SRED: begin
        lcg_nxt = {1'b0, fold_val};
        // The last TABLE_SIZE warm-up steps fill the table, top slot first.
        if (cnt_r < CW'(TABLE_SIZE)) begin
          ram_wr_en   = 1'b1;
          ram_wr_addr = cnt_r[AW-1:0];
        end
        if (cnt_r == '0) begin
          // The value written to slot zero becomes the previous sample.
          last_nxt  = fold_val;
          state_nxt = DRAW_ENTRY;
        end else begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = S_SMUL;
        end
      end
      S_DIV: begin
        q_nxt     = slot_quo;
        state_nxt = S_DMUL;
      end
      S_DMUL: begin
        prod_nxt  = lcg_r * slrs_pkg::MUL_A;
        ram_rd_en = 1'b1;
        state_nxt = S_DRED;
      end
      S_DRED: begin
        // Slot content goes out and is replaced by the new generator value.
        if (!out_valid_r || out_tready) begin
          ram_wr_en      = 1'b1;
          lcg_nxt        = {1'b0, fold_val};
          last_nxt       = ram_rd_data;
          out_sample_nxt = ram_rd_data;
          out_gen_nxt    = fold_val;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lcg_r       <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lcg_r       <= lcg_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r       <= prod_nxt;
    cnt_r        <= cnt_nxt;
    q_r          <= q_nxt;
    out_sample_r <= out_sample_nxt;
    out_gen_r    <= out_gen_nxt;
  end

  // Shuffle table.
  slrs_ram #(
    .WIDTH (31),
    .DEPTH (TABLE_SIZE)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (slot),
    .rd_data (ram_rd_data)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_gen_r, out_sample_r};

`ifndef NO_ASSERTIONS
  // An accepted item keeps the input side closed on the next cycle.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while an item is in progress");

  // A new result only appears from the final draw state.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !$past(out_tvalid)) |-> ($past(state_r) == S_DRED))
    else $error("result raised outside the final draw state");

  // Table writes stay inside the table.
  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |-> (ram_wr_addr <= AW'(TABLE_SIZE - 1)))
    else $error("table write beyond the last slot");

  // The folded generator value is always reduced below the modulus.
  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[61:31] != 31'h7FFF_FFFF))
    else $error("generator value not reduced");
`endif

endmodule

>>> hdl/slrs_ram.sv
// ----------------------------------------------------------------------------
// slrs_ram - generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module slrs_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
